@@ design/prrk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrk_pkg
// Types, constants and the trigonometry table of the per-bin range-rate filter.
// ----------------------------------------------------------------------------
package prrk_pkg;

    localparam int FULL_TURN    = 360;
    localparam int QUARTER_TURN = 90;
    localparam int HALF_TURN    = 180;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_AW      = 1;
    localparam int DIV_STEPS    = 17;

    localparam logic [31:0] NOISE_RESET = 32'd65536;
    localparam logic [16:0] GAIN_ONE    = 17'd65536;

    // Configuration register indexes
    localparam logic [7:0] CFG_SPEED_Q = 8'd0;
    localparam logic [7:0] CFG_SPEED_R = 8'd1;
    localparam logic [7:0] CFG_DIST_Q  = 8'd2;
    localparam logic [7:0] CFG_DIST_R  = 8'd3;

    // pi/180 in Q30
    localparam longint unsigned DEG_Q30 = 64'd18740330;
    localparam longint unsigned TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                     64'd110, 64'd156, 64'd210};

    typedef logic signed [15:0] t_trig_rom [0:FULL_TURN-1];

    typedef struct packed {
        logic [8:0]         bin;
        logic [15:0]        distance;
        logic signed [15:0] accel_fwd;
        logic signed [15:0] accel_side;
        logic signed [15:0] sin_v;
        logic signed [15:0] cos_v;
        logic               out_of_range;
    } t_item;

    typedef struct packed {
        logic [15:0]        prev_distance;
        logic signed [23:0] speed_estimate;
        logic [31:0]        speed_variance;
        logic signed [23:0] dist_estimate;
        logic [31:0]        dist_variance;
    } t_bin_state;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ACC,
        BK_PRED,
        BK_START,
        BK_DIV,
        BK_MUL,
        BK_UPD,
        BK_WRITE,
        BK_OOR
    } t_back_state;

    // Sine of 0..90 degrees in Q1.15 from a truncated Taylor series in Q30.
    function automatic logic signed [15:0] sin_quarter(input int unsigned a);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          r;
        x    = 64'(a) * DEG_Q30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[k];
            if (k[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        r = (sum + 64'sd16384) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        if (r < -64'sd32768) begin
            r = -64'sd32768;
        end
        return 16'(r);
    endfunction

    function automatic t_trig_rom build_sin_rom();
        t_trig_rom t;
        for (int a = 0; a < FULL_TURN; a++) begin
            if (a <= QUARTER_TURN) begin
                t[a] = sin_quarter(a);
            end else if (a <= HALF_TURN) begin
                t[a] = sin_quarter(HALF_TURN - a);
            end else if (a <= HALF_TURN + QUARTER_TURN) begin
                t[a] = -sin_quarter(a - HALF_TURN);
            end else begin
                t[a] = -sin_quarter(FULL_TURN - a);
            end
        end
        return t;
    endfunction

    localparam t_trig_rom SIN_ROM = build_sin_rom();

    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        if (v > 28'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -28'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    function automatic logic [31:0] sat32(input logic [32:0] v);
        return v[32] ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

@@ design/prrk_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrk_front
// Accepts items, resolves the angle and its sine and cosine, flags bins out of
// range, and queues them for the back end.
// ----------------------------------------------------------------------------
module prrk_front import prrk_pkg::*; #(
    parameter int NUM_BINS = 360
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [8:0]         i_bin,
    input  logic [15:0]        i_distance,
    input  logic signed [15:0] i_accel_fwd,
    input  logic signed [15:0] i_accel_side,
    input  logic               i_clearing,
    output logic               o_item_valid,
    output t_item              o_item,
    input  logic               i_item_pop
);

    t_item              r_ent [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_AW:0]   r_count;
    logic [8:0]         angle;
    logic [8:0]         cos_idx;
    logic [9:0]         cos_sum;
    logic               push;
    t_item              n_item;

    always_comb begin
        angle   = (i_bin >= 9'(FULL_TURN)) ? i_bin - 9'(FULL_TURN) : i_bin;
        cos_sum = {1'b0, angle} + 10'(QUARTER_TURN);
        cos_idx = (cos_sum >= 10'(FULL_TURN)) ? 9'(cos_sum - 10'(FULL_TURN))
                                               : cos_sum[8:0];
        n_item.bin          = i_bin;
        n_item.distance     = i_distance;
        n_item.accel_fwd    = i_accel_fwd;
        n_item.accel_side   = i_accel_side;
        n_item.sin_v        = SIN_ROM[angle];
        n_item.cos_v        = SIN_ROM[cos_idx];
        n_item.out_of_range = 32'(i_bin) >= 32'(NUM_BINS);
    end

    assign o_in_ready   = (r_count != (FIFO_AW + 1)'(FIFO_DEPTH)) && !i_clearing;
    assign push         = i_in_valid && o_in_ready;
    assign o_item_valid = r_count != '0;
    assign o_item       = r_ent[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_item_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(i_item_pop);
        end
    end

endmodule

@@ design/prrk_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrk_div
// Radix-2 restoring divider for the Kalman gain, floor(pm * 65536 / (pm + r)).
// ----------------------------------------------------------------------------
module prrk_div import prrk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_pm,
    input  logic [31:0] i_noise,
    output logic        o_done,
    output logic [16:0] o_gain
);

    logic [32:0] r_den;
    logic [32:0] r_rem;
    logic [16:0] r_shin;
    logic [16:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic        r_zero;
    logic [33:0] trial;
    logic        fits;

    // The quotient never exceeds 17 bits, so the top of the dividend starts as
    // the partial remainder and only its lowest 17 bits are shifted in.
    assign trial = {r_rem, r_shin[16]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= {1'b0, i_pm} + {1'b0, i_noise};
            r_rem  <= {2'b0, i_pm[31:1]};
            r_shin <= {i_pm[0], 16'd0};
            r_quo  <= '0;
            r_zero <= (i_pm == '0) && (i_noise == '0);
        end else if (r_busy) begin
            r_rem  <= fits ? 33'(trial - {1'b0, r_den}) : trial[32:0];
            r_shin <= {r_shin[15:0], 1'b0};
            r_quo  <= {r_quo[15:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gain = r_zero ? '0 : r_quo;

endmodule

@@ design/prrk_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrk_back
// Per-bin state memory and the sequencer that runs the speed filter and then
// the distance filter on one shared datapath and gain divider.
// ----------------------------------------------------------------------------
module prrk_back import prrk_pkg::*; #(
    parameter int NUM_BINS = 360
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  t_item              i_item,
    output logic               o_item_pop,
    output logic               o_clearing,
    input  logic [31:0]        i_speed_q,
    input  logic [31:0]        i_speed_r,
    input  logic [31:0]        i_dist_q,
    input  logic [31:0]        i_dist_r,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [8:0]         o_out_bin,
    output logic signed [23:0] o_speed_filtered,
    output logic signed [23:0] o_dist_filtered
);

    localparam int ADDR_W = $clog2(NUM_BINS);

    t_back_state        r_state;
    t_back_state        n_state;
    t_bin_state         r_mem [NUM_BINS];
    t_bin_state         r_rdata;
    t_bin_state         wdata;
    logic               mem_we;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  r_clr_addr;
    t_item              r_cur;
    logic signed [31:0] r_pc;
    logic signed [31:0] r_ps;
    logic signed [17:0] r_acc;
    logic signed [32:0] acc_sum;
    logic               r_phase;
    logic signed [23:0] r_xm;
    logic [31:0]        r_pm;
    logic signed [16:0] r_z;
    logic signed [43:0] r_kd;
    logic [48:0]        r_pv;
    logic signed [23:0] r_snew;
    logic [31:0]        r_svnew;
    logic signed [23:0] r_dnew;
    logic [31:0]        r_dvnew;
    logic signed [23:0] pred_x;
    logic [31:0]        pred_p;
    logic signed [16:0] pred_z;
    logic signed [25:0] diff;
    logic signed [43:0] kd_round;
    logic signed [23:0] upd_x;
    logic               div_start;
    logic               div_done;
    logic [16:0]        div_gain;
    logic               slot_free;
    logic               r_out_valid;
    logic [8:0]         r_out_bin;
    logic signed [23:0] r_out_speed;
    logic signed [23:0] r_out_dist;

    prrk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_pm    (r_pm),
        .i_noise (r_phase ? i_dist_r : i_speed_r),
        .o_done  (div_done),
        .o_gain  (div_gain)
    );

    assign slot_free  = !r_out_valid || i_out_ready;
    assign div_start  = r_state == BK_START;
    assign o_clearing = r_state == BK_CLEAR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_item_pop = 1'b0;
        unique case (r_state)
            BK_CLEAR: begin
                if (r_clr_addr == ADDR_W'(NUM_BINS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_state    = i_item.out_of_range ? BK_OOR : BK_ACC;
                end
            end
            BK_ACC:   n_state = BK_PRED;
            BK_PRED:  n_state = BK_START;
            BK_START: n_state = BK_DIV;
            BK_DIV: begin
                if (div_done) begin
                    n_state = BK_MUL;
                end
            end
            BK_MUL:   n_state = BK_UPD;
            BK_UPD:   n_state = r_phase ? BK_WRITE : BK_PRED;
            BK_WRITE, BK_OOR: begin
                if (slot_free) begin
                    n_state = BK_IDLE;
                end
            end
            default:  n_state = BK_IDLE;
        endcase
    end

    // Predict step: speed takes the projected acceleration, distance the new speed.
    always_comb begin
        if (!r_phase) begin
            pred_x = sat24(28'(r_rdata.speed_estimate) + 28'(r_acc));
            pred_p = sat32({1'b0, r_rdata.speed_variance} + {1'b0, i_speed_q});
            pred_z = $signed({1'b0, r_cur.distance}) - $signed({1'b0, r_rdata.prev_distance});
        end else begin
            pred_x = sat24(28'(r_rdata.dist_estimate) + 28'(r_snew));
            pred_p = sat32({1'b0, r_rdata.dist_variance} + {1'b0, i_dist_q});
            pred_z = $signed({1'b0, r_cur.distance});
        end
        acc_sum  = 33'(r_pc) + 33'(r_ps) + 33'sd16384;
        diff     = 26'(r_z) - 26'(r_xm);
        kd_round = r_kd + 44'sd32768;
        upd_x    = sat24(28'(r_xm) + kd_round[43:16]);
    end

    always_comb begin
        mem_we = 1'b0;
        waddr  = ADDR_W'(r_cur.bin);
        wdata  = '0;
        if (r_state == BK_CLEAR) begin
            mem_we = 1'b1;
            waddr  = r_clr_addr;
        end else if (r_state == BK_WRITE && slot_free) begin
            mem_we               = 1'b1;
            wdata.prev_distance  = r_cur.distance;
            wdata.speed_estimate = r_snew;
            wdata.speed_variance = r_svnew;
            wdata.dist_estimate  = r_dnew;
            wdata.dist_variance  = r_dvnew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
        if (o_item_pop) begin
            r_rdata <= r_mem[ADDR_W'(i_item.bin)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_cur <= i_item;
            r_pc  <= i_item.cos_v * i_item.accel_fwd;
            r_ps  <= i_item.sin_v * i_item.accel_side;
        end
        if (r_state == BK_ACC) begin
            r_acc <= acc_sum[32:15];
        end
        if (r_state == BK_PRED) begin
            r_xm <= pred_x;
            r_pm <= pred_p;
            r_z  <= pred_z;
        end
        if (r_state == BK_MUL) begin
            r_kd <= $signed({1'b0, div_gain}) * diff;
            r_pv <= (GAIN_ONE - div_gain) * r_pm;
        end
        if (r_state == BK_UPD) begin
            if (!r_phase) begin
                r_snew  <= upd_x;
                r_svnew <= r_pv[47:16];
            end else begin
                r_dnew  <= upd_x;
                r_dvnew <= r_pv[47:16];
            end
        end
        if ((r_state == BK_WRITE || r_state == BK_OOR) && slot_free) begin
            r_out_bin   <= r_cur.bin;
            r_out_speed <= (r_state == BK_WRITE) ? r_snew : '0;
            r_out_dist  <= (r_state == BK_WRITE) ? r_dnew : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (o_item_pop) begin
                r_phase <= 1'b0;
            end else if (r_state == BK_UPD) begin
                r_phase <= 1'b1;
            end
            if ((r_state == BK_WRITE || r_state == BK_OOR) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_bin        = r_out_bin;
    assign o_speed_filtered = r_out_speed;
    assign o_dist_filtered  = r_out_dist;

endmodule

@@ design/per_bin_range_rate_kalman_unit.sv @@
`timescale 1ns / 1ps
// The back end works on one item at a time, paced by the two 17-step gain
// divisions that share one divider; an out-of-range bin skips both filters.
// A two-item queue lets the input take items while the back end works.
// Reset: synchronous, active low; afterwards a pass over all bin addresses clears the
// bin memory, during which no item is taken (configuration writes still are).
// ----------------------------------------------------------------------------
// per_bin_range_rate_kalman_unit
// Per-bin range rate and distance tracker built from two cascaded scalar
// Kalman filters in fixed point.
// ----------------------------------------------------------------------------
module per_bin_range_rate_kalman_unit import prrk_pkg::*; #(
    parameter int NUM_BINS = 360
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [8:0]         i_bin,
    input  logic [15:0]        i_distance,
    input  logic signed [15:0] i_accel_fwd,
    input  logic signed [15:0] i_accel_side,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [8:0]         o_out_bin,
    output logic signed [23:0] o_speed_filtered,
    output logic signed [23:0] o_dist_filtered,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    logic [31:0] r_speed_q;
    logic [31:0] r_speed_r;
    logic [31:0] r_dist_q;
    logic [31:0] r_dist_r;
    logic        item_valid;
    t_item       item;
    logic        item_pop;
    logic        clearing;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_q <= NOISE_RESET;
            r_speed_r <= NOISE_RESET;
            r_dist_q  <= NOISE_RESET;
            r_dist_r  <= NOISE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SPEED_Q: r_speed_q <= i_cfg_data;
                CFG_SPEED_R: r_speed_r <= i_cfg_data;
                CFG_DIST_Q:  r_dist_q  <= i_cfg_data;
                CFG_DIST_R:  r_dist_r  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    prrk_front #(.NUM_BINS(NUM_BINS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_bin        (i_bin),
        .i_distance   (i_distance),
        .i_accel_fwd  (i_accel_fwd),
        .i_accel_side (i_accel_side),
        .i_clearing   (clearing),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    prrk_back #(.NUM_BINS(NUM_BINS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (item_valid),
        .i_item           (item),
        .o_item_pop       (item_pop),
        .o_clearing       (clearing),
        .i_speed_q        (r_speed_q),
        .i_speed_r        (r_speed_r),
        .i_dist_q         (r_dist_q),
        .i_dist_r         (r_dist_r),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_bin        (o_out_bin),
        .o_speed_filtered (o_speed_filtered),
        .o_dist_filtered  (o_dist_filtered)
    );

endmodule

@@ design/prrk_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrk_checker
// Port-level checks of the range-rate tracker, bound to the top level.
// ----------------------------------------------------------------------------
module prrk_checker #(
    parameter int NUM_BINS = 360
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [8:0]         o_out_bin,
    input logic signed [23:0] o_speed_filtered,
    input logic signed [23:0] o_dist_filtered
);

    // Reset starts the memory clearing pass, so no item may be taken next.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready) else $error("item taken during clearing pass");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("result shown straight after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_bin)
        && $stable(o_speed_filtered) && $stable(o_dist_filtered))
        else $error("stalled result changed");

    // A bin beyond the table touches no state and reports zero estimates.
    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (32'(o_out_bin) >= 32'(NUM_BINS)) |->
        o_speed_filtered == '0 && o_dist_filtered == '0)
        else $error("out-of-range bin gave non-zero estimates");

endmodule

bind per_bin_range_rate_kalman_unit prrk_checker #(.NUM_BINS(NUM_BINS)) u_prrk_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_out_bin        (o_out_bin),
    .o_speed_filtered (o_speed_filtered),
    .o_dist_filtered  (o_dist_filtered)
);
